// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL. The clock is clk and the reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define GN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the next cycle.
`define GN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GN_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gn_pkg.sv =====
`default_nettype none
package gn_pkg;

  localparam int GROUP_MAX = 64;
  localparam int ADDR_W    = $clog2(GROUP_MAX);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int ENTRY_W   = 48;

  // Divider geometry: remainder, shifted dividend and iteration count.
  localparam int DIV_REM_W  = 32;
  localparam int DIV_LO_W   = 52;
  localparam int DIV_ITER_W = 6;
  localparam logic [DIV_ITER_W-1:0] DIV_VAR_ITERS = 6'd52;
  localparam logic [DIV_ITER_W-1:0] DIV_OUT_ITERS = 6'd16;

  // Configuration register indexes.
  localparam logic [0:0] CFG_AFFINE  = 1'b0;
  localparam logic [0:0] CFG_EPSILON = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD, S_N2, S_N3, S_VAR, S_VDIV, S_VDIVW, S_SQRT, S_SQRTW, S_DEN,
    S_ORD, S_OD, S_OMUL, S_OSUM, S_OPRE, S_ODIV, S_OEMIT
  } gn_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_LO_W-1:0]   dividend;
    logic [DIV_ITER_W-1:0] iters;
    logic [DIV_REM_W-1:0]  divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/gn_ram.sv =====
`default_nettype none
module gn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gn_div.sv =====
`default_nettype none
module gn_div
  import gn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire div_req_t            req,
  output      logic                done,
  output      logic [DIV_LO_W-1:0] quot
);

  logic [DIV_REM_W-1:0]  rem_r, rem_nxt;
  logic [DIV_LO_W-1:0]   lo_r, lo_nxt;
  logic [DIV_REM_W-1:0]  dvs_r;
  logic [DIV_ITER_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_REM_W:0]    trial;
  logic                  ge;

  // One restoring step a cycle: a dividend bit in, a quotient bit out.
  assign trial = {rem_r, lo_r[DIV_LO_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem_init;
      lo_nxt   = req.dividend;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_REM_W'(trial - {1'b0, dvs_r}) : trial[DIV_REM_W-1:0];
      lo_nxt  = {lo_r[DIV_LO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule
`default_nettype wire

// ===== rtl/gn_sqrt.sv =====
`default_nettype none
module gn_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] radicand,
  output      logic        done,
  output      logic [23:0] root
);

  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [27:0] remsh;
  logic [27:0] trial;
  logic        ge;

  // Two radicand bits a step, one root bit out.
  assign remsh = {rem_r, rad_r[47:46]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = remsh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd23) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[45:0], 2'b00};
      rem_r  <= ge ? 26'(remsh - trial) : remsh[25:0];
      root_r <= {root_r[22:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== rtl/group_normalization_core.sv =====
// Group normalisation of a stream of Q8.8 samples.
// Input words carry sample, channel weight (Q4.12) and bias (Q8.8) in
// in_tdata; in_tlast marks the last element of a group. A group also closes
// by itself at its sixty-fourth element. Elements load one a cycle into the
// buffer memory while in_tready is high.
// When a group closes, in_tready drops while the block forms the statistics:
// a pass over the buffer, the variance division, the square root and the
// set-up of n squared, n cubed and the denominator. Each result is then
// formed by the bit-serial divider, or skips it when it saturates early.
// Results leave in arrival order on out_tdata, out_tlast on the last one.
// A result stays in the output register until out_tready takes it; while the
// receiver stalls the block waits and loses nothing.
// Configuration (affine enable, epsilon) is written through cfg_we while the
// block is idle. Reset empties the buffer count and sets epsilon to one.
`default_nettype none
`include "assert_macros.svh"
module group_normalization_core
  import gn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // sample, scale_weight, shift_bias
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // normalized
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  gn_state_t state_r, state_nxt;

  logic              aff_r;
  logic [15:0]       eps_r;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [21:0] sum_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [CNT_W-1:0]  oi_r;
  logic              v1_r, v2_r, v3_r;
  logic signed [23:0] d_r;
  logic [45:0]       sq_r;
  logic [50:0]       acc_r;
  logic [12:0]       n2_r;
  logic [18:0]       n3_r;
  logic [31:0]       var_r;
  logic [23:0]       r_r;
  logic [29:0]       den_r;
  logic signed [23:0] od_r;
  logic signed [15:0] ow_r, ob_r;
  logic signed [39:0] pw_r;
  logic signed [46:0] pb_r;
  logic signed [47:0] num_r;
  logic              neg_r, sat_r;
  logic [15:0]       q_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic              out_last_r;

  logic              in_fire, close, slot_free, oi_last;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic signed [15:0] rd_s, rd_w, rd_b;
  logic signed [23:0] d_calc;
  logic [47:0]       mag, mp;
  logic              presat;
  logic [15:0]       eps_eff;
  logic [15:0]       res;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_LO_W-1:0] div_quot;
  logic              sqrt_start, sqrt_done;
  logic [23:0]       sqrt_root;

  assign in_fire   = in_tvalid && in_tready;
  assign close     = in_tlast || (cnt_r == CNT_W'(GROUP_MAX - 1));
  assign slot_free = !out_valid_r || out_tready;
  assign oi_last   = (oi_r + 1'b1) == n_r;
  assign eps_eff   = (eps_r == 16'd0) ? 16'd1 : eps_r;

  // Buffer memory: one entry of sample, weight and bias per element.
  assign rd_s = ram_rdata[15:0];
  assign rd_w = ram_rdata[31:16];
  assign rd_b = ram_rdata[47:32];

  gn_ram #(.WIDTH(ENTRY_W), .DEPTH(GROUP_MAX)) u_buf (
    .clk   (clk),
    .we    (in_fire),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scaled difference from the mean: n*s - sum.
  assign d_calc = 24'($signed({1'b0, n_r}) * rd_s) - 24'(sum_r);

  // Rounded magnitude and the early saturation check.
  assign mag    = num_r[47] ? 48'(-num_r) : 48'(num_r);
  assign mp     = mag + {19'd0, den_r[29:1]};
  assign presat = mp[47:16] >= {2'b00, den_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (in_fire && close) state_nxt = S_N2;
      S_N2:    state_nxt = S_N3;
      S_N3:    state_nxt = S_VAR;
      S_VAR:   if (rd_cnt_r == n_r && !v1_r && !v2_r && !v3_r) state_nxt = S_VDIV;
      S_VDIV:  state_nxt = S_VDIVW;
      S_VDIVW: if (div_done) state_nxt = S_SQRT;
      S_SQRT:  state_nxt = S_SQRTW;
      S_SQRTW: if (sqrt_done) state_nxt = S_DEN;
      S_DEN:   state_nxt = S_ORD;
      S_ORD:   state_nxt = S_OD;
      S_OD:    state_nxt = S_OMUL;
      S_OMUL:  state_nxt = S_OSUM;
      S_OSUM:  state_nxt = S_OPRE;
      S_OPRE:  state_nxt = presat ? S_OEMIT : S_ODIV;
      S_ODIV:  if (div_done) state_nxt = S_OEMIT;
      S_OEMIT: if (slot_free) state_nxt = oi_last ? S_LOAD : S_ORD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = oi_r[ADDR_W-1:0];
    sqrt_start = 1'b0;
    div_req    = '0;
    case (state_r)
      S_LOAD: in_tready = 1'b1;
      S_VAR: begin
        ram_re    = rd_cnt_r != n_r;
        ram_raddr = rd_cnt_r[ADDR_W-1:0];
      end
      S_VDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, acc_r};
        div_req.iters    = DIV_VAR_ITERS;
        div_req.divisor  = {13'd0, n3_r};
      end
      S_SQRT: sqrt_start = 1'b1;
      S_ORD:  ram_re = 1'b1;
      S_OPRE: begin
        div_req.start    = !presat;
        div_req.rem_init = mp[47:16];
        div_req.dividend = {mp[15:0], 36'd0};
        div_req.iters    = DIV_OUT_ITERS;
        div_req.divisor  = {2'b00, den_r};
      end
      default: ;
    endcase
  end

  gn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  gn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand({var_r, 16'd0}),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  // Signed result with round-half-away already applied, then saturation.
  always_comb begin
    if (!neg_r) begin
      res = (sat_r || q_r[15]) ? 16'h7FFF : q_r;
    end else begin
      res = (sat_r || q_r > 16'd32768) ? 16'h8000 : 16'(-q_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      aff_r       <= 1'b0;
      eps_r       <= 16'd1;
      cnt_r       <= '0;
      sum_r       <= '0;
      rd_cnt_r    <= '0;
      oi_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_AFFINE:  aff_r <= cfg_wdata[0];
          CFG_EPSILON: eps_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + 22'(signed'(in_tdata[15:0]));
      end
      v1_r <= (state_r == S_VAR) && (rd_cnt_r != n_r);
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (state_r == S_N2) begin
        rd_cnt_r <= '0;
      end else if (state_r == S_VAR && rd_cnt_r != n_r) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (out_valid_r && out_tready && state_r != S_OEMIT) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DEN) begin
        oi_r <= '0;
      end else if (state_r == S_OEMIT && slot_free) begin
        out_valid_r <= 1'b1;
        oi_r        <= oi_r + 1'b1;
        if (oi_last) begin
          cnt_r <= '0;
          sum_r <= '0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire && close) begin
      n_r <= cnt_r + 1'b1;
    end
    if (state_r == S_N2) begin
      n2_r  <= 13'(n_r * n_r);
      acc_r <= '0;
    end
    if (state_r == S_N3) begin
      n3_r <= 19'(n2_r * n_r);
    end
    // Statistics pass: read, difference, square, accumulate.
    if (v1_r) begin
      d_r <= d_calc;
    end
    if (v2_r) begin
      sq_r <= 46'(d_r * d_r);
    end
    if (v3_r) begin
      acc_r <= acc_r + {5'd0, sq_r};
    end
    if (state_r == S_VDIVW && div_done) begin
      var_r <= div_quot[31:0] + {16'd0, eps_eff};
    end
    if (state_r == S_SQRTW && sqrt_done) begin
      r_r <= sqrt_root;
    end
    if (state_r == S_DEN) begin
      den_r <= 30'(n_r * r_r);
    end
    // Result pass.
    if (state_r == S_OD) begin
      od_r <= d_calc;
      ow_r <= rd_w;
      ob_r <= rd_b;
    end
    if (state_r == S_OMUL) begin
      pw_r <= ow_r * od_r;
      pb_r <= ob_r * $signed({1'b0, den_r});
    end
    if (state_r == S_OSUM) begin
      if (aff_r) begin
        num_r <= $signed({pw_r, 4'd0}) + 48'(pb_r);
      end else begin
        num_r <= $signed({od_r, 16'd0});
      end
    end
    if (state_r == S_OPRE) begin
      neg_r <= num_r[47];
      sat_r <= presat;
    end
    if (state_r == S_ODIV && div_done) begin
      q_r <= div_quot[15:0];
    end
    if (state_r == S_OEMIT && slot_free) begin
      out_data_r <= res;
      out_last_r <= oi_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `GN_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_r <= CNT_W'(GROUP_MAX), "element count above group size")
  `GN_ASSERT_NEXT(a_load_count, in_fire && !close, cnt_r == $past(cnt_r) + 1'b1, "count did not advance")
  `GN_ASSERT_IMPLY(a_sqrt_done, sqrt_done, state_r == S_SQRTW, "square root finished out of turn")
  `GN_ASSERT_IMPLY(a_div_done, div_done, state_r == S_VDIVW || state_r == S_ODIV, "divider finished out of turn")

endmodule
`default_nettype wire
